/* hw/rtl/tvn_pkg.sv */
// Shared constants and types for the tilt vector normaliser.
package tvn_pkg;

   // Default fraction bits of the tilt words
   localparam int unsigned FracBitsDefault = 14;
   // Width of a raw axis sample and of a tilt word
   localparam int unsigned AxisWidth = 16;
   localparam int unsigned TiltWidth = 16;
   // Width of a squared axis and of the squared magnitude
   localparam int unsigned SqWidth  = 31;
   localparam int unsigned MsqWidth = 33;

   // Control that travels down the chain beside each word
   typedef struct packed {
      logic valid;
      logic zero;
      logic neg_x;
      logic neg_y;
   } stage_ctl_type;

endpackage

/* hw/rtl/tvn_front.sv */
// Front end: squares the axes, sums the magnitude and seeds the residuals.
module tvn_front #(
   parameter int unsigned FRAC_BITS = tvn_pkg::FracBitsDefault,
   parameter int unsigned W         = 2 * FRAC_BITS + 36
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                req_valid,
   input  logic signed [tvn_pkg::AxisWidth-1:0] req_accel_x,
   input  logic signed [tvn_pkg::AxisWidth-1:0] req_accel_y,
   input  logic signed [tvn_pkg::AxisWidth-1:0] req_accel_z,
   output tvn_pkg::stage_ctl_type              ctl_out,
   output logic [tvn_pkg::MsqWidth-1:0]        msq_out,
   output logic [W-1:0]                        rx_out,
   output logic [W-1:0]                        ry_out
);

   localparam int unsigned SqW  = tvn_pkg::SqWidth;
   localparam int unsigned MsqW = tvn_pkg::MsqWidth;

   tvn_pkg::stage_ctl_type sq_ctl_ff, sq_ctl_in;
   logic [SqW-1:0]         sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SqW-1:0]         sq_x_in, sq_y_in, sq_z_in;
   tvn_pkg::stage_ctl_type ctl_ff, ctl_in;
   logic [MsqW-1:0]        msq_ff, msq_in;
   logic [W-1:0]           rx_ff, rx_in, ry_ff, ry_in;
   logic signed [2*tvn_pkg::AxisWidth-1:0] px, py, pz;

   // Square each axis
   always_comb begin
      px = req_accel_x * req_accel_x;
      py = req_accel_y * req_accel_y;
      pz = req_accel_z * req_accel_z;
      sq_x_in = px[SqW-1:0];
      sq_y_in = py[SqW-1:0];
      sq_z_in = pz[SqW-1:0];
      sq_ctl_in.valid = req_valid;
      sq_ctl_in.zero  = 1'b0;
      sq_ctl_in.neg_x = req_accel_x[tvn_pkg::AxisWidth-1];
      sq_ctl_in.neg_y = req_accel_y[tvn_pkg::AxisWidth-1];
   end

   // Sum the magnitude and scale the axis squares into residuals
   always_comb begin
      msq_in = MsqW'(sq_x_ff) + MsqW'(sq_y_ff) + MsqW'(sq_z_ff);
      rx_in  = W'(sq_x_ff) << (2 * FRAC_BITS);
      ry_in  = W'(sq_y_ff) << (2 * FRAC_BITS);
      ctl_in = sq_ctl_ff;
      ctl_in.zero = (msq_in == '0);
   end

   // Advance both stages together; only the valid bits take the reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl_ff.valid <= 1'b0;
         ctl_ff.valid    <= 1'b0;
      end else if (en) begin
         sq_ctl_ff.valid <= sq_ctl_in.valid;
         ctl_ff.valid    <= ctl_in.valid;
      end
      if (en) begin
         sq_ctl_ff.zero  <= sq_ctl_in.zero;
         sq_ctl_ff.neg_x <= sq_ctl_in.neg_x;
         sq_ctl_ff.neg_y <= sq_ctl_in.neg_y;
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_z_ff <= sq_z_in;
         ctl_ff.zero  <= ctl_in.zero;
         ctl_ff.neg_x <= ctl_in.neg_x;
         ctl_ff.neg_y <= ctl_in.neg_y;
         msq_ff <= msq_in;
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign msq_out = msq_ff;
   assign rx_out  = rx_ff;
   assign ry_out  = ry_ff;

endmodule

/* hw/rtl/tvn_cell.sv */
// One chain cell: settles one quotient bit for both lanes.
module tvn_cell #(
   parameter int unsigned FRAC_BITS = tvn_pkg::FracBitsDefault,
   parameter int unsigned W         = 2 * FRAC_BITS + 36,
   parameter int unsigned BIT       = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  tvn_pkg::stage_ctl_type       ctl_in_w,
   input  logic [tvn_pkg::MsqWidth-1:0] msq_in_w,
   input  logic [W-1:0]                 dx_in_w,
   input  logic [W-1:0]                 ex_in_w,
   input  logic [FRAC_BITS:0]           qx_in_w,
   input  logic [W-1:0]                 dy_in_w,
   input  logic [W-1:0]                 ey_in_w,
   input  logic [FRAC_BITS:0]           qy_in_w,
   output tvn_pkg::stage_ctl_type       ctl_out,
   output logic [tvn_pkg::MsqWidth-1:0] msq_out,
   output logic [W-1:0]                 dx_out,
   output logic [W-1:0]                 ex_out,
   output logic [FRAC_BITS:0]           qx_out,
   output logic [W-1:0]                 dy_out,
   output logic [W-1:0]                 ey_out,
   output logic [FRAC_BITS:0]           qy_out
);

   tvn_pkg::stage_ctl_type   ctl_ff;
   logic [tvn_pkg::MsqWidth-1:0] msq_ff;
   logic [W-1:0]             dx_ff, dx_in, ex_ff, ex_in, dy_ff, dy_in, ey_ff, ey_in;
   logic [FRAC_BITS:0]       qx_ff, qx_in, qy_ff, qy_in;
   logic [W-1:0]             msq_w, tx, ty;
   logic                     ok_x, ok_y;

   // Trial: (2*q*2^b + 2^2b) * msq against the residual, from shifts only
   always_comb begin
      msq_w = W'(msq_in_w);
      tx    = (ex_in_w << (BIT + 1)) + (msq_w << (2 * BIT));
      ty    = (ey_in_w << (BIT + 1)) + (msq_w << (2 * BIT));
      ok_x  = (tx <= dx_in_w);
      ok_y  = (ty <= dy_in_w);
      dx_in = ok_x ? dx_in_w - tx : dx_in_w;
      dy_in = ok_y ? dy_in_w - ty : dy_in_w;
      ex_in = ok_x ? ex_in_w + (msq_w << BIT) : ex_in_w;
      ey_in = ok_y ? ey_in_w + (msq_w << BIT) : ey_in_w;
      qx_in = qx_in_w | ((FRAC_BITS + 1)'(ok_x) << BIT);
      qy_in = qy_in_w | ((FRAC_BITS + 1)'(ok_y) << BIT);
   end

   // Hand the word on to the next cell; only the valid bit takes the reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in_w.valid;
      end
      if (en) begin
         ctl_ff.zero  <= ctl_in_w.zero;
         ctl_ff.neg_x <= ctl_in_w.neg_x;
         ctl_ff.neg_y <= ctl_in_w.neg_y;
         msq_ff <= msq_in_w;
         dx_ff  <= dx_in;
         ex_ff  <= ex_in;
         qx_ff  <= qx_in;
         dy_ff  <= dy_in;
         ey_ff  <= ey_in;
         qy_ff  <= qy_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign msq_out = msq_ff;
   assign dx_out  = dx_ff;
   assign ex_out  = ex_ff;
   assign qx_out  = qx_ff;
   assign dy_out  = dy_ff;
   assign ey_out  = ey_ff;
   assign qy_out  = qy_ff;

endmodule

/* hw/rtl/tilt_vector_normalizer_unit.sv */
// Throughput: one sample per cycle while no finished word is held by rsp_stall.
// The chain of FRAC_BITS + 1 bit cells, fed by the front end, is fully pipelined.
// Each cell settles one quotient bit with one wide compare and subtract per lane.
// The last cell is the output register; a stall freezes the whole chain.
// Reset (synchronous, active high) clears every stage valid; no result is pending after it.
module tilt_vector_normalizer_unit #(
   parameter int unsigned FRAC_BITS = tvn_pkg::FracBitsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tvn_pkg::AxisWidth-1:0] req_accel_x,
   input  logic signed [tvn_pkg::AxisWidth-1:0] req_accel_y,
   input  logic signed [tvn_pkg::AxisWidth-1:0] req_accel_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tvn_pkg::TiltWidth-1:0] rsp_tilt_x,
   output logic signed [tvn_pkg::TiltWidth-1:0] rsp_tilt_y,
   output logic                                 rsp_zero_vector
);

   localparam int unsigned W  = 2 * FRAC_BITS + 36;
   localparam int unsigned N  = FRAC_BITS + 1;
   localparam int unsigned QW = FRAC_BITS + 2;
   localparam int unsigned TW = tvn_pkg::TiltWidth;

   logic                         en;
   tvn_pkg::stage_ctl_type       ctl    [0:N];
   logic [tvn_pkg::MsqWidth-1:0] msq    [0:N];
   logic [W-1:0]                 dx     [0:N];
   logic [W-1:0]                 ex     [0:N];
   logic [FRAC_BITS:0]           qx     [0:N];
   logic [W-1:0]                 dy     [0:N];
   logic [W-1:0]                 ey     [0:N];
   logic [FRAC_BITS:0]           qy     [0:N];
   logic [QW-1:0]                sx, sy;
   logic [TW-1:0]                tx, ty;

   // Freeze the chain while a finished word waits
   assign en        = !(ctl[N].valid && rsp_stall);
   assign req_stall = !en;

   tvn_front #(.FRAC_BITS(FRAC_BITS), .W(W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .req_valid   (req_valid),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .ctl_out     (ctl[0]),
      .msq_out     (msq[0]),
      .rx_out      (dx[0]),
      .ry_out      (dy[0])
   );

   assign ex[0] = '0;
   assign ey[0] = '0;
   assign qx[0] = '0;
   assign qy[0] = '0;

   // Chain of bit cells, most significant quotient bit first
   for (genvar k = 0; k < N; k++) begin : g_cell
      tvn_cell #(.FRAC_BITS(FRAC_BITS), .W(W), .BIT(FRAC_BITS - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_in_w (ctl[k]),
         .msq_in_w (msq[k]),
         .dx_in_w  (dx[k]),
         .ex_in_w  (ex[k]),
         .qx_in_w  (qx[k]),
         .dy_in_w  (dy[k]),
         .ey_in_w  (ey[k]),
         .qy_in_w  (qy[k]),
         .ctl_out  (ctl[k+1]),
         .msq_out  (msq[k+1]),
         .dx_out   (dx[k+1]),
         .ex_out   (ex[k+1]),
         .qx_out   (qx[k+1]),
         .dy_out   (dy[k+1]),
         .ey_out   (ey[k+1]),
         .qy_out   (qy[k+1])
      );
   end

   // Apply the sign of each axis
   assign sx = ctl[N].neg_x ? QW'(0) - {1'b0, qx[N]} : {1'b0, qx[N]};
   assign sy = ctl[N].neg_y ? QW'(0) - {1'b0, qy[N]} : {1'b0, qy[N]};

   // Fit the signed quotient to the tilt word
   if (QW >= TW) begin : g_trunc
      assign tx = sx[TW-1:0];
      assign ty = sy[TW-1:0];
   end else begin : g_ext
      assign tx = {{(TW - QW){sx[QW-1]}}, sx};
      assign ty = {{(TW - QW){sy[QW-1]}}, sy};
   end

   // Drop the quotients for an all-zero sample
   assign rsp_valid       = ctl[N].valid;
   assign rsp_zero_vector = ctl[N].zero;
   assign rsp_tilt_x      = ctl[N].zero ? '0 : tx;
   assign rsp_tilt_y      = ctl[N].zero ? '0 : ty;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_zero_forces: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_vector) |-> (rsp_tilt_x == '0 && rsp_tilt_y == '0))
      else $error("zero vector with non-zero tilt");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_zero_vector) |->
         (qx[N] <= ((FRAC_BITS + 1)'(1) << FRAC_BITS) &&
          qy[N] <= ((FRAC_BITS + 1)'(1) << FRAC_BITS)))
      else $error("quotient above full scale");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(qx[N]) && $stable(qy[N])))
      else $error("chain advanced under stall");

endmodule
